### sv/dwsr_pkg.sv
package dwsr_pkg;

  localparam int SpeedW  = 16;
  localparam int DtW     = 16;
  localparam int RateW   = 24;
  localparam int TrimW   = 17;
  localparam int RefW    = 21;
  localparam int StepW   = 20;
  localparam int CfgIdxW = 4;
  localparam int ScaleW  = 12;
  localparam int LimitW  = 15;

  localparam logic [ScaleW-1:0] SPEED_SCALE    = 12'd1910;
  localparam logic [LimitW-1:0] SPEED_LIMIT_Q8 = 15'd5120;
  localparam logic [DtW-1:0]    DEFAULT_DT_US  = 16'd5000;
  localparam logic [DtW-1:0]    MAX_DT_US      = 16'd20000;

  localparam logic [RefW-1:0]          REF_MAG_MAX = 21'd1048575;
  localparam logic signed [RefW:0]     SUM_MAX     = 22'sd1048575;
  localparam logic signed [RefW:0]     SUM_MIN     = -22'sd1048576;

  typedef logic signed [RefW-1:0]  ref_t;
  typedef logic signed [TrimW-1:0] trim_t;
  typedef logic [StepW-1:0]        step_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UP_RATE    = 4'd0,
    CFG_DECEL_RATE = 4'd1,
    CFG_TRIM_IL    = 4'd2,
    CFG_TRIM_IR    = 4'd3,
    CFG_TRIM_ID    = 4'd4,
    CFG_TRIM_OL    = 4'd5,
    CFG_TRIM_OR    = 4'd6,
    CFG_TRIM_OD    = 4'd7
  } cfg_reg_t;

  function automatic ref_t speed_to_target(input logic signed [SpeedW-1:0] s);
    logic signed [SpeedW-1:0] lim;
    logic signed [SpeedW-1:0] c;
    logic [SpeedW-1:0]        negc;
    logic [LimitW-1:0]        mag;
    logic [26:0]              prod;
    logic [27:0]              rnd;
    logic [23:0]              scaled;
    logic [RefW-1:0]          m21;
    ref_t                     t;
    lim = $signed({1'b0, SPEED_LIMIT_Q8});
    c = s;
    if (s > lim) c = lim;
    if (s < -lim) c = -lim;
    negc = -c;
    mag = c[SpeedW-1] ? negc[LimitW-1:0] : c[LimitW-1:0];
    prod = 27'(mag) * 27'(SPEED_SCALE);
    rnd = {1'b0, prod} + 28'd8;
    scaled = rnd[27:4];
    m21 = (scaled > 24'(REF_MAG_MAX)) ? REF_MAG_MAX : scaled[RefW-1:0];
    t = c[SpeedW-1] ? -$signed(m21) : $signed(m21);
    if (s == '0) t = '0;
    return t;
  endfunction

  function automatic ref_t ramp(input ref_t cur, input ref_t tgt,
                                input step_t up, input step_t down);
    logic signed [RefW:0] cur22;
    logic signed [RefW:0] tgt22;
    logic signed [RefW:0] diff;
    logic signed [RefW:0] step22;
    logic signed [RefW:0] res;
    logic [RefW:0]        acur;
    logic [RefW:0]        atgt;
    cur22 = {cur[RefW-1], cur};
    tgt22 = {tgt[RefW-1], tgt};
    acur = cur22[RefW] ? -cur22 : cur22;
    atgt = tgt22[RefW] ? -tgt22 : tgt22;
    step22 = $signed({2'b00, (atgt > acur) ? up : down});
    diff = tgt22 - cur22;
    if (diff == '0) res = tgt22;
    else if (diff > step22) res = cur22 + step22;
    else if (diff < -step22) res = cur22 - step22;
    else res = tgt22;
    return res[RefW-1:0];
  endfunction

  function automatic ref_t wheel_ref(input ref_t base, input trim_t trim);
    logic signed [RefW:0] sum;
    ref_t                 r;
    sum = {base[RefW-1], base} + {{(RefW+1-TrimW){trim[TrimW-1]}}, trim};
    if (sum > SUM_MAX) r = SUM_MAX[RefW-1:0];
    else if (sum < SUM_MIN) r = SUM_MIN[RefW-1:0];
    else r = sum[RefW-1:0];
    if (base == '0) r = '0;
    return r;
  endfunction

endpackage

### sv/dual_wheel_speed_ramp_top.sv
// Dual-stage wheel speed ramp.
// Input stream (s_tvalid, s_tready, s_tdata) carries one control tick: the inner
// and outer target speeds and the time since the previous tick. Output stream
// (m_tvalid, m_tready, m_tdata) carries the six wheel references of that tick.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the up and down
// rates and the six wheel trims; the user must see that it is written only
// while no tick is in flight, as the block does not enforce it. A tick passes
// four registers: the input register, the target and step register (speed
// scaling and rate times time, two multipliers each), the two stage base
// references, and the output register. One tick per cycle is taken in steady
// state while the receiver does not stall; the rate is set by the base update,
// a compare and add loop. Reset clears all valid flags, both base references
// and all configuration registers. When the receiver stalls, the result holds
// in the output register and earlier stages keep filling until every stage
// holds a tick; only then does s_tready go low.
module dual_wheel_speed_ramp_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // inner_speed, outer_speed, elapsed_us
  input  logic [47:0]                       s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // ref_inner_left, ref_inner_right, ref_inner_down,
  // ref_outer_left, ref_outer_right, ref_outer_down, two zero bits
  output logic [127:0]                      m_tdata,
  input  logic                              cfg_we,
  input  logic [dwsr_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [dwsr_pkg::RateW-1:0]        cfg_data
);

  logic [dwsr_pkg::RateW-1:0] up_rate;
  logic [dwsr_pkg::RateW-1:0] decel_rate;
  dwsr_pkg::trim_t            trim [6];

  logic                            in_valid;
  logic signed [dwsr_pkg::SpeedW-1:0] in_inner;
  logic signed [dwsr_pkg::SpeedW-1:0] in_outer;
  logic [dwsr_pkg::DtW-1:0]        in_dt;

  logic                mid_valid;
  dwsr_pkg::ref_t      tgt_inner;
  dwsr_pkg::ref_t      tgt_outer;
  dwsr_pkg::step_t     step_up;
  dwsr_pkg::step_t     step_down;

  logic                ramp_valid;
  dwsr_pkg::ref_t      inner_base;
  dwsr_pkg::ref_t      outer_base;
  dwsr_pkg::ref_t      inner_base_next;
  dwsr_pkg::ref_t      outer_base_next;

  dwsr_pkg::ref_t      ref_out [6];

  logic                out_free;
  logic                load4;
  logic                ramp_free;
  logic                load3;
  logic                mid_free;
  logic                load2;
  logic                accept;

  logic [dwsr_pkg::DtW-1:0]   dt;
  logic [39:0]                up_prod;
  logic [39:0]                down_prod;
  logic                       inner_within;

  assign out_free  = !m_tvalid || m_tready;
  assign load4     = ramp_valid && out_free;
  assign ramp_free = !ramp_valid || load4;
  assign load3     = mid_valid && ramp_free;
  assign mid_free  = !mid_valid || load3;
  assign load2     = in_valid && mid_free;
  assign s_tready  = !in_valid || load2;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_rate    <= '0;
      decel_rate <= '0;
      for (int i = 0; i < 6; i++) trim[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dwsr_pkg::CFG_UP_RATE:    up_rate    <= cfg_data;
        dwsr_pkg::CFG_DECEL_RATE: decel_rate <= cfg_data;
        dwsr_pkg::CFG_TRIM_IL:    trim[0]    <= cfg_data[dwsr_pkg::TrimW-1:0];
        dwsr_pkg::CFG_TRIM_IR:    trim[1]    <= cfg_data[dwsr_pkg::TrimW-1:0];
        dwsr_pkg::CFG_TRIM_ID:    trim[2]    <= cfg_data[dwsr_pkg::TrimW-1:0];
        dwsr_pkg::CFG_TRIM_OL:    trim[3]    <= cfg_data[dwsr_pkg::TrimW-1:0];
        dwsr_pkg::CFG_TRIM_OR:    trim[4]    <= cfg_data[dwsr_pkg::TrimW-1:0];
        dwsr_pkg::CFG_TRIM_OD:    trim[5]    <= cfg_data[dwsr_pkg::TrimW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      mid_valid  <= 1'b0;
      ramp_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) in_valid <= 1'b1;
      else if (load2) in_valid <= 1'b0;
      if (load2) mid_valid <= 1'b1;
      else if (load3) mid_valid <= 1'b0;
      if (load3) ramp_valid <= 1'b1;
      else if (load4) ramp_valid <= 1'b0;
      if (load4) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_inner <= s_tdata[15:0];
      in_outer <= s_tdata[31:16];
      in_dt    <= s_tdata[47:32];
    end
  end

  always_comb begin
    if (in_dt == '0) dt = dwsr_pkg::DEFAULT_DT_US;
    else if (in_dt > dwsr_pkg::MAX_DT_US) dt = dwsr_pkg::MAX_DT_US;
    else dt = in_dt;
    up_prod   = 40'(up_rate) * 40'(dt);
    down_prod = 40'(decel_rate) * 40'(dt);
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      tgt_inner <= dwsr_pkg::speed_to_target(in_inner);
      tgt_outer <= dwsr_pkg::speed_to_target(in_outer);
      step_up   <= up_prod[39:20];
      step_down <= down_prod[39:20];
    end
  end

  assign inner_base_next = dwsr_pkg::ramp(inner_base, tgt_inner, step_up, step_down);
  assign outer_base_next = dwsr_pkg::ramp(outer_base, tgt_outer, step_up, step_down);

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_base <= '0;
      outer_base <= '0;
    end else if (load3) begin
      inner_base <= inner_base_next;
      outer_base <= outer_base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      ref_out[0] <= dwsr_pkg::wheel_ref(inner_base, trim[0]);
      ref_out[1] <= dwsr_pkg::wheel_ref(inner_base, trim[1]);
      ref_out[2] <= dwsr_pkg::wheel_ref(inner_base, trim[2]);
      ref_out[3] <= dwsr_pkg::wheel_ref(outer_base, trim[3]);
      ref_out[4] <= dwsr_pkg::wheel_ref(outer_base, trim[4]);
      ref_out[5] <= dwsr_pkg::wheel_ref(outer_base, trim[5]);
    end
  end

  assign m_tdata = {2'b00, ref_out[5], ref_out[4], ref_out[3],
                    ref_out[2], ref_out[1], ref_out[0]};

  assign inner_within =
    ((inner_base_next >= inner_base) && (inner_base_next <= tgt_inner)) ||
    ((inner_base_next <= inner_base) && (inner_base_next >= tgt_inner));

  a_base_between: assert property (@(posedge clk) disable iff (rst)
    load3 |-> inner_within)
    else $error("inner base left the range between old base and target");

  a_base_hold: assert property (@(posedge clk) disable iff (rst)
    (load3 && (tgt_outer == outer_base)) |=> $stable(outer_base))
    else $error("outer base moved although it matched its target");

  a_zero_base: assert property (@(posedge clk) disable iff (rst)
    (load4 && (inner_base == '0)) |=> (m_tdata[62:0] == '0))
    else $error("zero inner base gave nonzero wheel references");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !in_valid && !mid_valid && !ramp_valid))
    else $error("pipeline not empty after reset");

endmodule
